>>> rtl/lnp_pkg.sv
// shared types and constants for the l2 vector norm projection block
// no dependencies; imported by every module of the block
package lnp_pkg;

  localparam int MAX_LENGTH_DEF = 64;
  localparam int ELEM_W         = 24;
  localparam int RAD_W          = 24;
  localparam int OUT_W          = 25;
  localparam int NORM_W         = 27;
  localparam int SUM_W          = 53;
  localparam int PROD_W         = 48;
  localparam int CFG_IDX_W      = 1;
  localparam int SQRT_STEPS     = 27;
  localparam int DIV_STEPS      = 24;
  localparam int STEP_W         = 5;

  localparam logic [CFG_IDX_W-1:0] REG_RADIUS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_MODE   = 1'b1;

  localparam logic [RAD_W-1:0] RADIUS_RESET = 24'd65536;
  localparam logic             MODE_BALL    = 1'b0;
  localparam logic             MODE_SPHERE  = 1'b1;

  typedef enum logic [3:0] {
    S_LOAD,
    S_FLUSH,
    S_SQINIT,
    S_SQRT,
    S_READ,
    S_MUL,
    S_DINIT,
    S_DIV,
    S_OUT
  } lnp_state_t;

  typedef struct packed {
    logic load;
    logic sq_init;
    logic sq_step;
    logic rd;
    logic mul;
    logic d_init;
    logic d_step;
    logic out_load;
    logic advance;
    logic finish;
  } lnp_cmd_t;

  typedef struct packed {
    logic in_last;
    logic sq_last;
    logic d_last;
    logic rescale;
    logic last_k;
  } lnp_sts_t;

endpackage

>>> rtl/lnp_ctrl.sv
// controller state machine: sequences load, square root, per-element scaling and emit
// depends on lnp_pkg
module lnp_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  output logic             out_valid,
  input  logic             out_stall,
  input  lnp_pkg::lnp_sts_t sts,
  output lnp_pkg::lnp_cmd_t cmd
);
  import lnp_pkg::*;

  lnp_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_LOAD:   if (in_valid && sts.in_last) state_next = S_FLUSH;
      S_FLUSH:  state_next = S_SQINIT;
      S_SQINIT: state_next = S_SQRT;
      S_SQRT:   if (sts.sq_last) state_next = S_READ;
      S_READ:   state_next = S_MUL;
      S_MUL:    state_next = sts.rescale ? S_DINIT : S_OUT;
      S_DINIT:  state_next = S_DIV;
      S_DIV:    if (sts.d_last) state_next = S_OUT;
      S_OUT: begin
        if (!out_stall) state_next = sts.last_k ? S_LOAD : S_READ;
      end
      default:  state_next = S_LOAD;
    endcase
  end

  always_comb begin
    cmd          = '0;
    in_stall     = (state != S_LOAD);
    out_valid    = (state == S_OUT);
    cmd.load     = (state == S_LOAD) && in_valid;
    cmd.sq_init  = (state == S_SQINIT);
    cmd.sq_step  = (state == S_SQRT);
    cmd.rd       = (state == S_READ);
    cmd.mul      = (state == S_MUL);
    cmd.d_init   = (state == S_DINIT);
    cmd.d_step   = (state == S_DIV);
    cmd.out_load = ((state == S_MUL) && !sts.rescale) || ((state == S_DIV) && sts.d_last);
    cmd.advance  = (state == S_OUT) && !out_stall && !sts.last_k;
    cmd.finish   = (state == S_OUT) && !out_stall && sts.last_k;
  end

endmodule

>>> rtl/lnp_dp.sv
// datapath: element memory, square accumulator, bit-pair square root, restoring divider
// depends on lnp_pkg
module lnp_dp #(
  parameter int MAX_LENGTH = lnp_pkg::MAX_LENGTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [lnp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lnp_pkg::RAD_W-1:0]     cfg_data,
  input  logic signed [lnp_pkg::ELEM_W-1:0] element,
  input  logic                          last_element,
  output logic signed [lnp_pkg::OUT_W-1:0] scaled_element,
  output logic [lnp_pkg::NORM_W-1:0]    vector_norm,
  output logic                          last_result,
  output logic                          overflow,
  input  lnp_pkg::lnp_cmd_t             cmd,
  output lnp_pkg::lnp_sts_t             sts
);
  import lnp_pkg::*;

  localparam int AW = (MAX_LENGTH > 1) ? $clog2(MAX_LENGTH) : 1;
  localparam int CW = $clog2(MAX_LENGTH + 1);
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_LENGTH);

  logic [ELEM_W-1:0] mem [MAX_LENGTH];

  logic [RAD_W-1:0]  radius;
  logic              mode;
  logic [CW-1:0]     count;
  logic              ovf;
  logic [PROD_W-1:0] sq_prod;
  logic              sq_prod_vld;
  logic [SUM_W-1:0]  sum;

  logic [SUM_W:0]    rad_sh;
  logic [NORM_W-1:0] rem;
  logic [NORM_W-1:0] root;
  logic [STEP_W-1:0] sq_cnt;

  logic [AW-1:0]     k;
  logic [ELEM_W-1:0] rd_data;
  logic [PROD_W-1:0] sc_prod;
  logic              neg;
  logic [NORM_W-1:0] drem;
  logic [ELEM_W-1:0] dlow;
  logic [RAD_W-1:0]  quo;
  logic [STEP_W-1:0] d_cnt;

  logic              room;
  logic [ELEM_W-1:0] in_mag;
  logic [ELEM_W-1:0] rd_mag;
  logic [NORM_W+1:0] sq_ext;
  logic [NORM_W+1:0] sq_trial;
  logic              sq_ge;
  logic [NORM_W:0]   d_ext;
  logic              d_ge;
  logic [RAD_W-1:0]  quo_next;
  logic [OUT_W-1:0]  q_ext;
  logic [OUT_W-1:0]  out_val;

  assign room   = (count < MAX_CNT);
  assign in_mag = element[ELEM_W-1] ? (~element + 1'b1) : element;
  assign rd_mag = rd_data[ELEM_W-1] ? (~rd_data + 1'b1) : rd_data;

  // square root step: bring down two bits, try subtracting 4*root+1
  assign sq_ext   = {rem, rad_sh[SUM_W:SUM_W-1]};
  assign sq_trial = {root, 2'b01};
  assign sq_ge    = (sq_ext >= sq_trial);

  // divide step: bring down one bit of the low half
  assign d_ext    = {drem, dlow[ELEM_W-1]};
  assign d_ge     = (d_ext >= {1'b0, root});
  assign quo_next = {quo[RAD_W-2:0], d_ge};
  assign q_ext    = {1'b0, quo_next};
  assign out_val  = !sts.rescale ? {rd_data[ELEM_W-1], rd_data}
                  : (neg ? (~q_ext + 1'b1) : q_ext);

  assign sts.in_last = last_element;
  assign sts.sq_last = (sq_cnt == STEP_W'(SQRT_STEPS - 1));
  assign sts.d_last  = (d_cnt == STEP_W'(DIV_STEPS - 1));
  assign sts.rescale = (mode == MODE_SPHERE) ? (root != '0) : (root > NORM_W'(radius));
  assign sts.last_k  = ((CW'(k) + 1'b1) == count);

  assign vector_norm = root;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      radius <= RADIUS_RESET;
      mode   <= MODE_BALL;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_RADIUS: radius <= cfg_data;
        REG_MODE:   mode   <= cfg_data[0];
        default:    ;
      endcase
    end
  end

  // element memory
  always_ff @(posedge clk) begin
    if (cmd.load && room) mem[count[AW-1:0]] <= element;
    if (cmd.rd) rd_data <= mem[k];
  end

  // load bookkeeping and sum of squares
  always_ff @(posedge clk) begin
    if (rst) begin
      count       <= '0;
      ovf         <= 1'b0;
      sum         <= '0;
      sq_prod_vld <= 1'b0;
    end else begin
      sq_prod_vld <= cmd.load && room;
      if (sq_prod_vld) sum <= sum + SUM_W'(sq_prod);
      if (cmd.load) begin
        if (room) count <= count + 1'b1;
        else      ovf   <= 1'b1;
      end
      if (cmd.finish) begin
        count <= '0;
        ovf   <= 1'b0;
        sum   <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) sq_prod <= in_mag * in_mag;
  end

  // square root and emit index
  always_ff @(posedge clk) begin
    if (cmd.sq_init) begin
      rad_sh <= {1'b0, sum};
      rem    <= '0;
      root   <= '0;
      sq_cnt <= '0;
      k      <= '0;
    end else begin
      if (cmd.sq_step) begin
        rad_sh <= {rad_sh[SUM_W-2:0], 2'b00};
        sq_cnt <= sq_cnt + 1'b1;
        if (sq_ge) begin
          rem  <= NORM_W'(sq_ext - sq_trial);
          root <= {root[NORM_W-2:0], 1'b1};
        end else begin
          rem  <= NORM_W'(sq_ext);
          root <= {root[NORM_W-2:0], 1'b0};
        end
      end
      if (cmd.advance) k <= k + 1'b1;
    end
  end

  // scaling: product then restoring division by the norm
  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      sc_prod <= rd_mag * radius;
      neg     <= rd_data[ELEM_W-1];
    end
    if (cmd.d_init) begin
      drem  <= NORM_W'(sc_prod[PROD_W-1:ELEM_W]);
      dlow  <= sc_prod[ELEM_W-1:0];
      quo   <= '0;
      d_cnt <= '0;
    end else if (cmd.d_step) begin
      drem  <= d_ge ? NORM_W'(d_ext - {1'b0, root}) : NORM_W'(d_ext);
      dlow  <= {dlow[ELEM_W-2:0], 1'b0};
      quo   <= quo_next;
      d_cnt <= d_cnt + 1'b1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      scaled_element <= out_val;
      last_result    <= sts.last_k;
      overflow       <= ovf;
    end
  end

endmodule

>>> rtl/l2_vector_norm_projection_top.sv
// l2 ball / sphere projection: loads a vector one element per cycle, then emits every element,
// rescaled to the radius when the mode and norm call for it, else as it was loaded; no new
// vector is taken until the last beat is emitted; each beat waits on a memory read and a product,
// and when rescaled on the divider (one quotient bit a cycle); the 27-step square root runs once
// per vector. reset (rst, synchronous, active high) clears the fsm, counts, sum and flags;
// radius returns to 1.0 and mode to ball, the element memory is left as is
module l2_vector_norm_projection_top #(
  parameter int MAX_LENGTH = lnp_pkg::MAX_LENGTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  // configuration write port
  input  logic                              cfg_write,
  input  logic [lnp_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [lnp_pkg::RAD_W-1:0]         cfg_data,
  // input beats
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [lnp_pkg::ELEM_W-1:0] element,
  input  logic                              last_element,
  // result beats
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [lnp_pkg::OUT_W-1:0]  scaled_element,
  output logic [lnp_pkg::NORM_W-1:0]        vector_norm,
  output logic                              last_result,
  output logic                              overflow
);
  import lnp_pkg::*;

  lnp_cmd_t cmd;
  lnp_sts_t sts;

  // state machine: input beats are only taken in the load state
  lnp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // storage and arithmetic
  lnp_dp #(
    .MAX_LENGTH (MAX_LENGTH)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .element        (element),
    .last_element   (last_element),
    .scaled_element (scaled_element),
    .vector_norm    (vector_norm),
    .last_result    (last_result),
    .overflow       (overflow),
    .cmd            (cmd),
    .sts            (sts)
  );

endmodule

>>> rtl/lnp_checker.sv
// port-level checks for the projection block, bound to the top level
// depends on lnp_pkg and l2_vector_norm_projection_top
module lnp_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_stall,
  input logic last_element,
  input logic out_valid,
  input logic out_stall,
  input logic last_result
);
  import lnp_pkg::*;

  // results still pending are never dropped
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid) else $error("result beat dropped");

  // no input taken while a result is on offer
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall) else $error("input taken during emit");

  // the norm takes time after the last element
  a_last_gap: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && last_element |=> !out_valid) else $error("result too early");

  // next element needs a memory read first
  a_beat_gap: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !last_result |=> !out_valid) else $error("beat gap missing");

  a_reset: assert property (@(posedge clk)
    rst |=> !out_valid) else $error("result after reset");

endmodule

bind l2_vector_norm_projection_top lnp_checker u_lnp_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_stall     (in_stall),
  .last_element (last_element),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .last_result  (last_result)
);
